>>> rtl/prs_pkg.sv
// Shared constants for the polyline resampler.
// No dependencies; imported by every rtl/prs_* module and polyline_resampler.
`default_nettype none
package prs_pkg;
	localparam int COORD_BITS = 24;
	localparam int MAX_STEPS  = 63;
	localparam int RES_W      = 23;
	localparam int STEP_W     = $clog2(MAX_STEPS + 1);
	localparam int MAG_W      = COORD_BITS;
	localparam int SQ_W       = 2 * MAG_W;
	localparam int D2_W       = SQ_W + 1;
	localparam int ACC_W      = SQ_W + 2 * STEP_W - 2;
	localparam int CNT_W      = $clog2(MAG_W);
	localparam logic [RES_W-1:0] RES_RESET = RES_W'(256);
	localparam logic [CNT_W-1:0] CNT_LAST  = CNT_W'(MAG_W - 1);
	localparam logic [STEP_W-1:0] STEP_MAX = STEP_W'(MAX_STEPS);
endpackage
`default_nettype wire

>>> rtl/prs_square.sv
// Bit-serial squarer: one multiplier bit per cycle, shift-and-add over all MAG_W bits of the operand.
// Depends on prs_pkg.
`default_nettype none
module prs_square import prs_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [MAG_W-1:0] opnd,
	output logic             done,
	output logic [SQ_W-1:0]  prod
);
	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [MAG_W-1:0] mplr_q;
	logic [SQ_W-1:0]  mcand_q;
	logic [SQ_W-1:0]  acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= !start && busy_q && (cnt_q == CNT_LAST);
			if (start) begin
				busy_q  <= 1'b1;
				cnt_q   <= '0;
				mplr_q  <= opnd;
				mcand_q <= SQ_W'(opnd);
				acc_q   <= '0;
			end else if (busy_q) begin
				if (mplr_q[0]) begin
					acc_q <= acc_q + mcand_q;
				end
				mcand_q <= {mcand_q[SQ_W-2:0], 1'b0};
				mplr_q  <= {1'b0, mplr_q[MAG_W-1:1]};
				cnt_q   <= cnt_q + 1'b1;
				if (cnt_q == CNT_LAST) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	assign done = done_q;
	assign prod = acc_q;
endmodule
`default_nettype wire

>>> rtl/prs_div.sv
// Bit-serial restoring divider, magnitude by step count, floored for sign.
// Depends on prs_pkg.
`default_nettype none
module prs_div import prs_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [MAG_W-1:0]         dvd,
	input  logic                     neg,
	input  logic [STEP_W-1:0]        dvs,
	output logic                     done,
	output logic signed [MAG_W:0]    quot,
	output logic [STEP_W-1:0]        rmd
);
	logic              busy_q;
	logic              done_q;
	logic              neg_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [MAG_W-1:0]  quo_q;
	logic [STEP_W-1:0] rem_q;
	logic [STEP_W-1:0] dvs_q;
	logic [STEP_W:0]   trial;
	logic              fit;
	logic [MAG_W:0]    qext;

	assign trial = {rem_q, quo_q[MAG_W-1]};
	assign fit   = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= !start && busy_q && (cnt_q == CNT_LAST);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
				quo_q  <= dvd;
				rem_q  <= '0;
				dvs_q  <= dvs;
				neg_q  <= neg;
			end else if (busy_q) begin
				rem_q <= fit ? STEP_W'(trial - {1'b0, dvs_q}) : trial[STEP_W-1:0];
				quo_q <= {quo_q[MAG_W-2:0], fit};
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_LAST) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// floor for negative dividends: q = -qa - 1, r = s - ra when ra is nonzero
	assign qext = {1'b0, quo_q};
	assign quot = !neg_q ? $signed(qext) :
		(rem_q != '0) ? $signed(~qext) : $signed(-qext);
	assign rmd  = (neg_q && rem_q != '0) ? dvs_q - rem_q : rem_q;
	assign done = done_q;
endmodule
`default_nettype wire

>>> rtl/polyline_resampler.sv
// Polyline resampler top level: step-count search, sequencer and output register.
// Depends on prs_pkg, prs_square and prs_div.
//
//  channel | handshake          | payload
//  --------+--------------------+------------------------------------------------
//  in      | in_valid/in_ready  | point_x, point_y, final_waypoint
//  out     | out_valid/out_ready| out_x, out_y, run_end, path_end, step_clamped
//  cfg     | cfg_we (no wait)   | cfg_wdata -> resolution
//
// One item at a time. An item with a segment passes through the serial
// squarers, then one search step per candidate step count, then the serial
// dividers, then emits one point per cycle while the output is not stalled.
// The first waypoint of a path without the final mark is only stored, in ST_END.
// Reset clears the stored point and sets resolution to 256.
// A stalled output holds the current item; the sequencer waits on it.
`default_nettype none
module polyline_resampler import prs_pkg::*; (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic signed [COORD_BITS-1:0] point_x,
	input  logic signed [COORD_BITS-1:0] point_y,
	input  logic                         final_waypoint,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic signed [COORD_BITS-1:0] out_x,
	output logic signed [COORD_BITS-1:0] out_y,
	output logic                         run_end,
	output logic                         path_end,
	output logic                         step_clamped,
	input  logic                         cfg_we,
	input  logic [RES_W-1:0]             cfg_wdata
);
	typedef enum logic [2:0] {
		ST_IDLE, ST_SQ, ST_SEARCH, ST_DIV, ST_EMIT, ST_LAST, ST_END
	} state_t;

	state_t state_q;

	logic [RES_W-1:0]      res_q;
	logic [COORD_BITS-1:0] prev_x_q, prev_y_q, px_q, py_q;
	logic                  have_prev_q, fin_q, clamp_q;
	logic [MAG_W-1:0]      ax_q, ay_q;
	logic                  nx_q, ny_q;
	logic                  sq_start_q, div_start_q;
	logic [D2_W-1:0]       d2_q;
	logic [ACC_W-1:0]      acc_q, dlt_q;
	logic [STEP_W-1:0]     t_q, s_q, j_q;
	logic signed [MAG_W:0] qdx_q, qdy_q, qx_q, qy_q;
	logic [STEP_W-1:0]     rdx_q, rdy_q, rx_q, ry_q;

	logic                  ovalid_q, orun_q, opath_q, oclamp_q;
	logic [COORD_BITS-1:0] ox_q, oy_q;

	logic                  sqx_done, sqy_done, sqr_done;
	logic [SQ_W-1:0]       sqx, sqy, sqr;
	logic                  dvx_done, dvy_done;
	logic signed [MAG_W:0] dvx_q, dvy_q;
	logic [STEP_W-1:0]     dvx_r, dvy_r;

	logic [MAG_W:0]        dx, dy;
	logic                  ld;
	logic [STEP_W:0]       rx_sum, ry_sum;
	logic                  rx_wrap, ry_wrap;
	logic                  hit, go_div, emit_now;

	assign dx = {point_x[COORD_BITS-1], point_x} - {prev_x_q[COORD_BITS-1], prev_x_q};
	assign dy = {point_y[COORD_BITS-1], point_y} - {prev_y_q[COORD_BITS-1], prev_y_q};

	assign ld      = !ovalid_q || out_ready;
	assign rx_sum  = {1'b0, rx_q} + {1'b0, rdx_q};
	assign ry_sum  = {1'b0, ry_q} + {1'b0, rdy_q};
	assign rx_wrap = rx_sum >= {1'b0, s_q};
	assign ry_wrap = ry_sum >= {1'b0, s_q};

	// search ends with a nonzero step count: start the dividers
	assign hit      = acc_q >= ACC_W'(d2_q);
	assign go_div   = (state_q == ST_SEARCH) && (hit || t_q == STEP_MAX) &&
		!(hit && t_q == '0);
	// a new item enters the output register this cycle
	assign emit_now = ld && (state_q == ST_EMIT || state_q == ST_LAST);

	prs_square u_sqx (.clk, .arst_n, .start(sq_start_q), .opnd(ax_q),
		.done(sqx_done), .prod(sqx));
	prs_square u_sqy (.clk, .arst_n, .start(sq_start_q), .opnd(ay_q),
		.done(sqy_done), .prod(sqy));
	prs_square u_sqr (.clk, .arst_n, .start(sq_start_q), .opnd(MAG_W'(res_q)),
		.done(sqr_done), .prod(sqr));

	prs_div u_dvx (.clk, .arst_n, .start(div_start_q), .dvd(ax_q), .neg(nx_q),
		.dvs(s_q), .done(dvx_done), .quot(dvx_q), .rmd(dvx_r));
	prs_div u_dvy (.clk, .arst_n, .start(div_start_q), .dvd(ay_q), .neg(ny_q),
		.dvs(s_q), .done(dvy_done), .quot(dvy_q), .rmd(dvy_r));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_q <= RES_RESET;
		end else if (cfg_we) begin
			res_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			prev_x_q    <= '0;
			prev_y_q    <= '0;
			have_prev_q <= 1'b0;
			sq_start_q  <= 1'b0;
			div_start_q <= 1'b0;
			ovalid_q    <= 1'b0;
			clamp_q     <= 1'b0;
			fin_q       <= 1'b0;
			s_q         <= '0;
			j_q         <= '0;
			t_q         <= '0;
		end else begin
			sq_start_q  <= (state_q == ST_IDLE) && in_valid && have_prev_q;
			div_start_q <= go_div;
			if (ovalid_q && out_ready && !emit_now) begin
				ovalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						px_q    <= point_x;
						py_q    <= point_y;
						fin_q   <= final_waypoint;
						clamp_q <= 1'b0;
						nx_q    <= dx[MAG_W];
						ny_q    <= dy[MAG_W];
						ax_q    <= dx[MAG_W] ? MAG_W'(-dx) : dx[MAG_W-1:0];
						ay_q    <= dy[MAG_W] ? MAG_W'(-dy) : dy[MAG_W-1:0];
						if (have_prev_q) begin
							state_q <= ST_SQ;
						end else begin
							state_q <= final_waypoint ? ST_LAST : ST_END;
						end
					end
				end
				ST_SQ: begin
					if (sqx_done) begin
						d2_q    <= {1'b0, sqx} + {1'b0, sqy};
						acc_q   <= '0;
						dlt_q   <= ACC_W'(sqr);
						t_q     <= '0;
						state_q <= ST_SEARCH;
					end
				end
				ST_SEARCH: begin
					// advance t with (t+1)^2 r^2 = t^2 r^2 + (2t+1) r^2
					if (hit || t_q == STEP_MAX) begin
						s_q     <= t_q;
						clamp_q <= !hit;
						if (hit && t_q == '0) begin
							state_q <= fin_q ? ST_LAST : ST_END;
						end else begin
							state_q <= ST_DIV;
						end
					end else begin
						acc_q <= acc_q + dlt_q;
						dlt_q <= dlt_q + ACC_W'({sqr, 1'b0});
						t_q   <= t_q + 1'b1;
					end
				end
				ST_DIV: begin
					if (dvx_done) begin
						qdx_q   <= dvx_q;
						qdy_q   <= dvy_q;
						rdx_q   <= dvx_r;
						rdy_q   <= dvy_r;
						qx_q    <= '0;
						qy_q    <= '0;
						rx_q    <= '0;
						ry_q    <= '0;
						j_q     <= '0;
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (ld) begin
						ovalid_q <= 1'b1;
						ox_q     <= prev_x_q + qx_q[COORD_BITS-1:0];
						oy_q     <= prev_y_q + qy_q[COORD_BITS-1:0];
						orun_q   <= (j_q == s_q - 1'b1) && !fin_q;
						opath_q  <= 1'b0;
						oclamp_q <= clamp_q;
						qx_q     <= qx_q + qdx_q + (MAG_W+1)'(rx_wrap);
						qy_q     <= qy_q + qdy_q + (MAG_W+1)'(ry_wrap);
						rx_q     <= rx_wrap ? STEP_W'(rx_sum - {1'b0, s_q}) : rx_sum[STEP_W-1:0];
						ry_q     <= ry_wrap ? STEP_W'(ry_sum - {1'b0, s_q}) : ry_sum[STEP_W-1:0];
						j_q      <= j_q + 1'b1;
						if (j_q == s_q - 1'b1) begin
							state_q <= fin_q ? ST_LAST : ST_END;
						end
					end
				end
				ST_LAST: begin
					if (ld) begin
						ovalid_q <= 1'b1;
						ox_q     <= px_q;
						oy_q     <= py_q;
						orun_q   <= 1'b1;
						opath_q  <= 1'b1;
						oclamp_q <= clamp_q;
						state_q  <= ST_END;
					end
				end
				ST_END: begin
					// drop the stored point after the final waypoint
					prev_x_q    <= fin_q ? '0 : px_q;
					prev_y_q    <= fin_q ? '0 : py_q;
					have_prev_q <= !fin_q;
					state_q     <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign in_ready     = (state_q == ST_IDLE);
	assign out_valid    = ovalid_q;
	assign out_x        = ox_q;
	assign out_y        = oy_q;
	assign run_end      = orun_q;
	assign path_end     = opath_q;
	assign step_clamped = oclamp_q;

	a_emit_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |-> (s_q != '0 && j_q < s_q))
		else $error("emission with an empty or overrun step count");
	a_clamp_max: assert property (@(posedge clk) disable iff (!arst_n)
		(clamp_q && (state_q == ST_EMIT || state_q == ST_DIV)) |-> (s_q == STEP_MAX))
		else $error("clamped segment without the maximum step count");
	a_sq_in_step: assert property (@(posedge clk) disable iff (!arst_n)
		sqx_done |-> (sqy_done && sqr_done && state_q == ST_SQ))
		else $error("squarers out of step");
	a_div_in_step: assert property (@(posedge clk) disable iff (!arst_n)
		dvx_done |-> (dvy_done && state_q == ST_DIV))
		else $error("dividers out of step");
endmodule
`default_nettype wire
